>>> design/fhq_pkg.sv
`default_nettype none
package fhq_pkg;
  localparam logic [1:0] WPN_EPEE  = 2'd0;
  localparam logic [1:0] WPN_FOIL  = 2'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BACK = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [2:0] REG_WEAPON      = 3'd0;
  localparam logic [2:0] REG_EPEE_MIN    = 3'd1;
  localparam logic [2:0] REG_EPEE_WIN    = 3'd2;
  localparam logic [2:0] REG_FOIL_MIN    = 3'd3;
  localparam logic [2:0] REG_FOIL_LOCK   = 3'd4;
  localparam logic [2:0] REG_SABRE_MIN   = 3'd5;
  localparam logic [2:0] REG_SABRE_LOCK  = 3'd6;
  localparam logic [2:0] REG_SABRE_BREAK = 3'd7;

  localparam int unsigned CFG_W = 20;
  localparam logic [CFG_W-1:0] BLADE_LATEST_US   = 20'd5000;
  localparam logic [CFG_W-1:0] BLADE_RECOVERY_US = 20'd20000;

  typedef struct packed {
    logic [1:0]       weapon;
    logic [CFG_W-1:0] epee_min;
    logic [CFG_W-1:0] epee_win;
    logic [CFG_W-1:0] foil_min;
    logic [CFG_W-1:0] foil_lock;
    logic [CFG_W-1:0] sabre_min;
    logic [CFG_W-1:0] sabre_lock;
    logic [CFG_W-1:0] sabre_break;
  } cfg_t;

  // Per-side contact lines, highest bit first (tip_shut is bit 0)
  typedef struct packed {
    logic ctl_broken;
    logic blade_seen;
    logic off_tgt;
    logic tip_open;
    logic tip_shut;
  } lines_t;
endpackage
`default_nettype wire

>>> design/fhq_cfg_regs.sv
`default_nettype none
module fhq_cfg_regs (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [19:0]          cfg_wdata,
  output fhq_pkg::cfg_t             cfg
);
  import fhq_pkg::*;
  cfg_t cfg_r;

  // Hold register file, write one entry per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weapon      <= WPN_EPEE;
      cfg_r.epee_min    <= 20'd2000;
      cfg_r.epee_win    <= 20'd45000;
      cfg_r.foil_min    <= 20'd13000;
      cfg_r.foil_lock   <= 20'd300000;
      cfg_r.sabre_min   <= 20'd100;
      cfg_r.sabre_lock  <= 20'd170000;
      cfg_r.sabre_break <= 20'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEAPON:      cfg_r.weapon      <= cfg_wdata[1:0];
        REG_EPEE_MIN:    cfg_r.epee_min    <= cfg_wdata;
        REG_EPEE_WIN:    cfg_r.epee_win    <= cfg_wdata;
        REG_FOIL_MIN:    cfg_r.foil_min    <= cfg_wdata;
        REG_FOIL_LOCK:   cfg_r.foil_lock   <= cfg_wdata;
        REG_SABRE_MIN:   cfg_r.sabre_min   <= cfg_wdata;
        REG_SABRE_LOCK:  cfg_r.sabre_lock  <= cfg_wdata;
        REG_SABRE_BREAK: cfg_r.sabre_break <= cfg_wdata;
        default: ;
      endcase
    end
  end
  assign cfg = cfg_r;
endmodule
`default_nettype wire

>>> design/fhq_core.sv
`default_nettype none
module fhq_core #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned MAX_HITS  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fhq_pkg::cfg_t        cfg,
  input  wire logic                 step,
  input  wire logic [TIME_BITS-1:0] t,
  input  wire fhq_pkg::lines_t      ln_l,
  input  wire fhq_pkg::lines_t      ln_r,
  output logic [1:0]                status,
  output logic [1:0]                n_hits,
  output logic [1:0]                h_side,
  output logic [1:0]                h_off,
  output logic [TIME_BITS-1:0]      h_start [2],
  output logic [TIME_BITS-1:0]      h_qual [2],
  output logic                      locked,
  output logic                      white_l,
  output logic                      white_r
);
  import fhq_pkg::*;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  logic [1:0]           reg_r, cact_r, coff_r, btrk_r, bract_r, white_r_r;
  logic [TIME_BITS-1:0] cst_r [2];
  logic [TIME_BITS-1:0] bst_r [2];
  logic [TIME_BITS-1:0] brst_r [2];
  logic                 plock_r, fseen_r, pseen_r;
  logic [TIME_BITS-1:0] ftime_r, lend_r, ptime_r;
  logic [CW-1:0]        cnt_r;

  logic [1:0]           reg_nxt, cact_nxt, coff_nxt, btrk_nxt, bract_nxt, white_nxt;
  logic [TIME_BITS-1:0] cst_nxt [2];
  logic [TIME_BITS-1:0] bst_nxt [2];
  logic [TIME_BITS-1:0] brst_nxt [2];
  logic                 plock_nxt, fseen_nxt;
  logic [TIME_BITS-1:0] ftime_nxt, lend_nxt;
  logic [CW-1:0]        cnt_nxt;

  lines_t               ln [2];
  logic [1:0]           got;
  logic [TIME_BITS-1:0] gst [2];
  logic [1:0]           goff;
  logic                 swap, commit, ovf;
  logic [TIME_BITS-1:0] lockv, firstq, dwin;
  logic [1:0]           keep;
  logic [CW:0]          cadd;
  logic [1:0]           pend;

  assign ln[0] = ln_l;
  assign ln[1] = ln_r;

  // Elapsed time with wrap, as the timers count in the time width
  function automatic logic [TIME_BITS-1:0] el(input logic [TIME_BITS-1:0] a,
                                              input logic [TIME_BITS-1:0] b);
    el = a - b;
  endfunction

  function automatic logic inwin(input logic [TIME_BITS-1:0] s,
                                 input logic [TIME_BITS-1:0] f,
                                 input logic [TIME_BITS-1:0] w);
    inwin = (s <= f) || ((s - f) <= w);
  endfunction

  always_comb begin
    logic                 hist, ready;
    logic [TIME_BITS-1:0] cs;
    reg_nxt = reg_r; cact_nxt = cact_r; coff_nxt = coff_r; btrk_nxt = btrk_r;
    bract_nxt = bract_r; white_nxt = white_r_r;
    cst_nxt = cst_r; bst_nxt = bst_r; brst_nxt = brst_r;
    plock_nxt = plock_r; fseen_nxt = fseen_r; ftime_nxt = ftime_r; lend_nxt = lend_r;
    cnt_nxt = cnt_r;
    got = 2'b00; goff = 2'b00; gst[0] = '0; gst[1] = '0;
    ovf = 1'b0; keep = 2'b00; cadd = '0; pend = 2'b00;
    swap = 1'b0; firstq = '0;
    dwin = {{(TIME_BITS-CFG_W){1'b0}}, cfg.epee_win};
    lockv = (cfg.weapon == WPN_FOIL) ? {{(TIME_BITS-CFG_W){1'b0}}, cfg.foil_lock}
                                     : {{(TIME_BITS-CFG_W){1'b0}}, cfg.sabre_lock};
    hist = 1'b0; ready = 1'b0; cs = '0;

    if (cfg.weapon == WPN_EPEE) begin
      // Epee: qualify closed-tip time per side, then window check
      if (!plock_r) begin
        for (int k = 0; k < 2; k++) begin
          if (!reg_r[k]) begin
            if (!ln[k].tip_shut) begin
              cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
            end else if (!cact_r[k]) begin
              cact_nxt[k] = 1'b1; cst_nxt[k] = t;
            end else if (el(t, cst_r[k]) >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.epee_min}) begin
              got[k] = 1'b1; gst[k] = cst_r[k];
              reg_nxt[k] = 1'b1; cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
            end
          end
        end
        swap = (got == 2'b11) && (gst[0] > gst[1]);
        // First hit in processing order sets the reference time
        if (!fseen_r) begin
          if (got != 2'b00) begin
            fseen_nxt = 1'b1;
            ftime_nxt = (got[0] && !swap) ? gst[0] : gst[1];
          end
          keep = got;
        end else begin
          keep[0] = got[0] && inwin(gst[0], ftime_r, dwin);
          keep[1] = got[1] && inwin(gst[1], ftime_r, dwin);
        end
        // Second hit checked against the first when both land together
        if (!fseen_r && got == 2'b11) begin
          if (swap) keep[0] = inwin(gst[0], gst[1], dwin);
          else      keep[1] = inwin(gst[1], gst[0], dwin);
        end
        cadd = {{CW{1'b0}}, keep[0]} + {{CW{1'b0}}, keep[1]};
        ovf = ({1'b0, cnt_r} + cadd) > (CW+1)'(MAX_HITS);
        cnt_nxt = CW'({1'b0, cnt_r} + cadd);
        if (fseen_nxt && el(t, ftime_nxt) > dwin) begin
          for (int k = 0; k < 2; k++)
            pend[k] = cact_nxt[k] && inwin(cst_nxt[k], ftime_nxt, dwin);
          plock_nxt = (pend == 2'b00);
        end
      end
      got = keep;
    end else begin
      // Foil and sabre: lockout then per-side qualification
      if (plock_r || (fseen_r && t >= lend_r)) begin
        plock_nxt = 1'b1;
        cact_nxt = 2'b00; cst_nxt[0] = '0; cst_nxt[1] = '0;
      end else begin
        for (int k = 0; k < 2; k++) begin
          if (cfg.weapon == WPN_FOIL) begin
            if (reg_r[k] || !ln[k].tip_open) begin
              cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
            end else begin
              cs = cst_r[k];
              if (!cact_r[k] || coff_r[k] != ln[k].off_tgt) begin
                cact_nxt[k] = 1'b1; coff_nxt[k] = ln[k].off_tgt; cs = t;
              end
              cst_nxt[k] = cs;
              if (el(t, cs) >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.foil_min}) begin
                got[k] = 1'b1; gst[k] = cs; goff[k] = ln[k].off_tgt;
                reg_nxt[k] = 1'b1; cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
              end
            end
          end else begin
            // Blade history window
            if (!btrk_r[k]) begin
              if (!ln[k].off_tgt && ln[k].blade_seen) begin
                btrk_nxt[k] = 1'b1; bst_nxt[k] = t;
              end
              hist = btrk_nxt[k];
            end else if (el(t, bst_r[k]) >= {{(TIME_BITS-CFG_W){1'b0}}, BLADE_RECOVERY_US}) begin
              btrk_nxt[k] = 1'b0; hist = 1'b0;
            end else begin
              hist = 1'b1;
            end
            ready = !ln[k].off_tgt;
            if (hist && el(t, bst_nxt[k]) > {{(TIME_BITS-CFG_W){1'b0}}, BLADE_LATEST_US})
              ready = 1'b0;
            // Control break timing for the white lamp
            if (ln[k].ctl_broken) begin
              cs = bract_r[k] ? brst_r[k] : t;
              bract_nxt[k] = 1'b1; brst_nxt[k] = cs;
              if (el(t, cs) >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.sabre_break})
                white_nxt[k] = 1'b1;
            end else begin
              bract_nxt[k] = 1'b0;
            end
            if (reg_r[k] || !ready) begin
              cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
            end else begin
              cs = cact_r[k] ? cst_r[k] : t;
              cact_nxt[k] = 1'b1; cst_nxt[k] = cs;
              if (el(t, cs) >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.sabre_min}) begin
                got[k] = 1'b1; gst[k] = cs;
                reg_nxt[k] = 1'b1; cact_nxt[k] = 1'b0; cst_nxt[k] = '0;
              end
            end
          end
        end
        swap = (got == 2'b11) && (gst[0] > gst[1]);
        cadd = {{CW{1'b0}}, got[0]} + {{CW{1'b0}}, got[1]};
        ovf = ({1'b0, cnt_r} + cadd) > (CW+1)'(MAX_HITS);
        cnt_nxt = CW'({1'b0, cnt_r} + cadd);
        if (!fseen_r && got != 2'b00) begin
          firstq = t;
          if ((TMAX - firstq) < lockv) ovf = 1'b1;
          fseen_nxt = 1'b1; ftime_nxt = firstq; lend_nxt = firstq + lockv;
        end
      end
    end
  end

  assign commit = step && !(pseen_r && t < ptime_r) && !ovf;

  // Update phrase state only on a good sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r <= '0; cact_r <= '0; coff_r <= '0; btrk_r <= '0; bract_r <= '0;
      white_r_r <= '0; plock_r <= 1'b0; fseen_r <= 1'b0; pseen_r <= 1'b0;
      cnt_r <= '0; ftime_r <= '0; lend_r <= '0; ptime_r <= '0;
      cst_r[0] <= '0; cst_r[1] <= '0; bst_r[0] <= '0; bst_r[1] <= '0;
      brst_r[0] <= '0; brst_r[1] <= '0;
    end else if (commit) begin
      reg_r <= reg_nxt; cact_r <= cact_nxt; coff_r <= coff_nxt; btrk_r <= btrk_nxt;
      bract_r <= bract_nxt; white_r_r <= white_nxt; plock_r <= plock_nxt;
      fseen_r <= fseen_nxt; cnt_r <= cnt_nxt; ftime_r <= ftime_nxt; lend_r <= lend_nxt;
      pseen_r <= 1'b1; ptime_r <= t;
      cst_r <= cst_nxt; bst_r <= bst_nxt; brst_r <= brst_nxt;
    end
  end

  // Result view: ordered hits and state after this sample
  always_comb begin
    logic good;
    good = !(pseen_r && t < ptime_r) && !ovf;
    status = (pseen_r && t < ptime_r) ? ST_BACK : (ovf ? ST_OVF : ST_OK);
    n_hits = good ? ({1'b0, got[0]} + {1'b0, got[1]}) : 2'd0;
    // Right hit goes first when it is alone or started earlier
    if (got == 2'b10 || (got == 2'b11 && swap)) begin
      h_side[0] = 1'b1; h_off[0] = goff[1]; h_start[0] = gst[1];
      h_side[1] = 1'b0; h_off[1] = goff[0]; h_start[1] = gst[0];
    end else begin
      h_side[0] = 1'b0; h_off[0] = goff[0]; h_start[0] = gst[0];
      h_side[1] = 1'b1; h_off[1] = goff[1]; h_start[1] = gst[1];
    end
    h_qual[0] = t; h_qual[1] = t;
    locked  = good ? plock_nxt : plock_r;
    white_l = cfg.weapon[1] && (good ? white_nxt[0] : white_r_r[0]);
    white_r = cfg.weapon[1] && (good ? white_nxt[1] : white_r_r[1]);
  end
endmodule
`default_nettype wire

>>> design/fencing_hit_qualifier.sv
`default_nettype none
// Channel   Dir  Payload
// in_       in   tdata: sample time, then per-side contact lines
// out_      out  tdata: status and hit fields, tlast: final result of sample
// cfg_      in   write enable, index, data
// One sample is taken per cycle when the output stage is free; a sample
// with two hits holds the input until the first result is taken and the
// second moves up. Results appear from the result register in the cycle
// after acceptance. Reset (rst_n low, synchronous)
// restores register defaults and clears all phrase state.
module fencing_hit_qualifier #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned MAX_HITS  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [47:0] sample_time_us, [48] left tip_shut, [49] left tip_open,
  // [50] left off_tgt, [51] left blade_seen, [52] left ctl_broken,
  // [53] right tip_shut, [54] right tip_open, [55] right off_tgt,
  // [56] right blade_seen, [57] right ctl_broken
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status_code, [2] hit_valid, [3] hit_side, [4] hit_off_target,
  // [52:5] hit_start_us, [100:53] hit_qualified_us, [101] locked_out,
  // [102] white_left, [103] white_right
  output logic [103:0]     out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);
  import fhq_pkg::*;

  cfg_t                 cfg;
  lines_t               ln_l, ln_r;
  logic [TIME_BITS-1:0] t;
  logic                 step;
  logic [1:0]           status, n_hits, h_side, h_off;
  logic [TIME_BITS-1:0] h_start [2];
  logic [TIME_BITS-1:0] h_qual [2];
  logic                 locked, white_l, white_r;

  logic                 v_r, last_r, pend_r;
  logic [103:0]         d_r, pend_d_r;

  fhq_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg
  );

  assign t    = TIME_BITS'(in_tdata[47:0]);
  assign ln_l = in_tdata[52:48];
  assign ln_r = in_tdata[57:53];

  // Accept when the result register is empty or drains this cycle and no second hit waits
  assign in_tready = !pend_r && (!v_r || out_tready);
  assign step      = in_tvalid && in_tready;

  fhq_core #(.TIME_BITS(TIME_BITS), .MAX_HITS(MAX_HITS)) u_core (
    .clk, .rst_n, .cfg, .step, .t, .ln_l, .ln_r,
    .status, .n_hits, .h_side, .h_off, .h_start, .h_qual,
    .locked, .white_l, .white_r
  );

  function automatic logic [103:0] pack(input logic [1:0] st, input logic hv,
                                        input logic sd, input logic of,
                                        input logic [TIME_BITS-1:0] s,
                                        input logic [TIME_BITS-1:0] q,
                                        input logic lk, input logic wl, input logic wr);
    pack = {wr, wl, lk, 48'(q), 48'(s), of, sd, hv, st};
  endfunction

  // Load result register, park a second hit for the next slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0; pend_r <= 1'b0; last_r <= 1'b0;
    end else if (step) begin
      v_r    <= 1'b1;
      pend_r <= (n_hits == 2'd2);
      last_r <= (n_hits != 2'd2);
      if (n_hits == 2'd0)
        d_r <= pack(status, 1'b0, 1'b0, 1'b0, '0, '0, locked, white_l, white_r);
      else
        d_r <= pack(status, 1'b1, h_side[0], h_off[0], h_start[0], h_qual[0],
                    locked, white_l, white_r);
      pend_d_r <= pack(status, 1'b1, h_side[1], h_off[1], h_start[1], h_qual[1],
                       locked, white_l, white_r);
    end else if (v_r && out_tready) begin
      if (pend_r) begin
        d_r <= pend_d_r; last_r <= 1'b1; pend_r <= 1'b0;
      end else begin
        v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = d_r;
  assign out_tlast  = last_r;
endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
  import fhq_pkg::*;

  localparam logic [1:0] WPN_SABRE = 2'd2;
  localparam logic [1:0] WPN_ALT   = 2'd3;  // unused weapon code, behaves as sabre
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [19:0] CFG_MAX  = 20'hFFFFF;
  localparam int LIMIT = 400000;
  localparam int NHITS = 4;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [103:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  fencing_hit_qualifier dut (.*);

  always #6 clk = ~clk;

  // scoring state of the predictor
  typedef struct {
    logic registered[2];
    logic cand_on[2];
    logic [47:0] cand_start[2];
    logic cand_off[2];
    logic blade_on[2];
    logic [47:0] blade_start[2];
    logic brk_on[2];
    logic [47:0] brk_start[2];
    logic lamp[2];
    logic locked;
    logic first_seen;
    logic [47:0] first_t;
    logic [47:0] lock_end;
    int nstored;
    logic prev_seen;
    logic [47:0] prev_t;
  } score_t;

  typedef struct {
    logic [57:0] d;
    bit gate;
  } sample_t;

  score_t sc, nx;
  logic [19:0] creg[8];
  logic hit_side[2], hit_off[2];
  logic [47:0] hit_start[2], hit_qual[2];
  int nhit;

  logic [104:0] results_due[$];
  sample_t samples_todo[$];
  int errors = 0;
  int cycles = 0;
  int idle_mode = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  logic quiet = 1;
  logic [47:0] cur_t = 0;
  logic [9:0] cur_lines = '0;

  function automatic logic [19:0] cfg_reset_value(int i);
    case (i)
      REG_EPEE_MIN:    return 20'd2000;
      REG_EPEE_WIN:    return 20'd45000;
      REG_FOIL_MIN:    return 20'd13000;
      REG_FOIL_LOCK:   return 20'd300000;
      REG_SABRE_MIN:   return 20'd100;
      REG_SABRE_LOCK:  return 20'd170000;
      REG_SABRE_BREAK: return 20'd3000;
      default:         return '0;
    endcase
  endfunction

  function automatic void drop_cand(int k);
    nx.cand_on[k] = 0;
    nx.cand_start[k] = '0;
  endfunction

  function automatic void record_hit(int k, logic off, logic [47:0] t);
    hit_side[nhit] = k[0];
    hit_off[nhit] = off;
    hit_start[nhit] = nx.cand_start[k];
    hit_qual[nhit] = t;
    nhit++;
    nx.registered[k] = 1;
    drop_cand(k);
  endfunction

  function automatic void epee_side(int k, logic [4:0] c, logic [47:0] t);
    logic [47:0] el;
    if (nx.registered[k]) return;
    if (!c[0]) begin
      drop_cand(k);
      return;
    end
    if (!nx.cand_on[k]) begin
      nx.cand_on[k] = 1;
      nx.cand_start[k] = t;
      return;
    end
    el = t - nx.cand_start[k];
    if (el < {28'd0, creg[REG_EPEE_MIN]}) return;
    record_hit(k, 1'b0, t);
  endfunction

  function automatic void foil_side(int k, logic [4:0] c, logic [47:0] t);
    logic [47:0] el;
    if (nx.registered[k] || !c[1]) begin
      drop_cand(k);
      return;
    end
    if (!nx.cand_on[k] || nx.cand_off[k] != c[2]) begin
      nx.cand_on[k] = 1;
      nx.cand_off[k] = c[2];
      nx.cand_start[k] = t;
    end
    el = t - nx.cand_start[k];
    if (el < {28'd0, creg[REG_FOIL_MIN]}) return;
    record_hit(k, c[2], t);
  endfunction

  function automatic void sabre_side(int k, logic [4:0] c, logic [47:0] t);
    logic hist, ready;
    logic [47:0] el;
    // blade history: a recent blade contact blocks the touch
    if (!nx.blade_on[k]) begin
      if (!c[2] && c[3]) begin
        nx.blade_on[k] = 1;
        nx.blade_start[k] = t;
      end
      hist = nx.blade_on[k];
    end else if (48'(t - nx.blade_start[k]) >= {28'd0, BLADE_RECOVERY_US}) begin
      nx.blade_on[k] = 0;
      hist = 0;
    end else begin
      hist = 1;
    end
    ready = !c[2];
    if (hist && 48'(t - nx.blade_start[k]) > {28'd0, BLADE_LATEST_US}) ready = 0;
    // control break timing for the white lamp
    if (c[4]) begin
      if (!nx.brk_on[k]) begin
        nx.brk_on[k] = 1;
        nx.brk_start[k] = t;
      end
      if (48'(t - nx.brk_start[k]) >= {28'd0, creg[REG_SABRE_BREAK]}) nx.lamp[k] = 1;
    end else begin
      nx.brk_on[k] = 0;
    end
    if (nx.registered[k] || !ready) begin
      drop_cand(k);
      return;
    end
    if (!nx.cand_on[k]) begin
      nx.cand_on[k] = 1;
      nx.cand_start[k] = t;
    end
    el = t - nx.cand_start[k];
    if (el < {28'd0, creg[REG_SABRE_MIN]}) return;
    record_hit(k, 1'b0, t);
  endfunction

  function automatic void order_hits();
    logic s0, o0;
    logic [47:0] a0, q0;
    if (nhit == 2 && hit_start[0] > hit_start[1]) begin
      s0 = hit_side[0]; o0 = hit_off[0]; a0 = hit_start[0]; q0 = hit_qual[0];
      hit_side[0] = hit_side[1]; hit_off[0] = hit_off[1];
      hit_start[0] = hit_start[1]; hit_qual[0] = hit_qual[1];
      hit_side[1] = s0; hit_off[1] = o0; hit_start[1] = a0; hit_qual[1] = q0;
    end
  endfunction

  function automatic logic in_window(logic [47:0] st, logic [47:0] first);
    return st <= first || (st - first) <= {28'd0, creg[REG_EPEE_WIN]};
  endfunction

  // returns reported hit indexes in sel, or -1 when the hit store overflows
  function automatic int run_epee(logic [57:0] s, output int sel[2]);
    logic [47:0] t = s[47:0];
    int m = 0;
    logic pending;
    sel[0] = 0; sel[1] = 0;
    if (nx.locked) return 0;
    for (int k = 0; k < 2; k++) epee_side(k, s[48 + 5 * k +: 5], t);
    order_hits();
    for (int i = 0; i < nhit; i++) begin
      if (!nx.first_seen) begin
        nx.first_seen = 1;
        nx.first_t = hit_start[i];
      end else if (!in_window(hit_start[i], nx.first_t)) begin
        continue;
      end
      if (nx.nstored >= NHITS) return -1;
      nx.nstored++;
      sel[m++] = i;
    end
    if (nx.first_seen && 48'(t - nx.first_t) > {28'd0, creg[REG_EPEE_WIN]}) begin
      pending = 0;
      for (int k = 0; k < 2; k++)
        if (nx.cand_on[k] && in_window(nx.cand_start[k], nx.first_t)) pending = 1;
      nx.locked = !pending;
    end
    return m;
  endfunction

  function automatic int run_latched(logic [57:0] s, logic foil);
    logic [47:0] t = s[47:0];
    logic [19:0] lock = foil ? creg[REG_FOIL_LOCK] : creg[REG_SABRE_LOCK];
    if (nx.locked || (nx.first_seen && t >= nx.lock_end)) begin
      nx.locked = 1;
      drop_cand(0);
      drop_cand(1);
      return 0;
    end
    for (int k = 0; k < 2; k++)
      if (foil) foil_side(k, s[48 + 5 * k +: 5], t);
      else sabre_side(k, s[48 + 5 * k +: 5], t);
    order_hits();
    for (int i = 0; i < nhit; i++) begin
      if (nx.nstored >= NHITS) return -1;
      nx.nstored++;
    end
    if (!nx.first_seen && nhit > 0) begin
      if (TIME_MAX - hit_qual[0] < {28'd0, lock}) return -1;
      nx.first_seen = 1;
      nx.first_t = hit_qual[0];
      nx.lock_end = hit_qual[0] + {28'd0, lock};
    end
    return nhit;
  endfunction

  function automatic void queue_result(logic [1:0] status, int h, logic last);
    logic sabre = creg[REG_WEAPON][1];
    logic hv = h >= 0;
    logic [47:0] a = hv ? hit_start[h] : '0;
    logic [47:0] q = hv ? hit_qual[h] : '0;
    logic sd = hv ? hit_side[h] : 1'b0;
    logic of = hv ? hit_off[h] : 1'b0;
    results_due.push_back({last, sabre & sc.lamp[1], sabre & sc.lamp[0], sc.locked,
                           q, a, of, sd, hv, status});
  endfunction

  // work out the results of one accepted sample
  function automatic void score_sample(logic [57:0] s);
    logic [47:0] t = s[47:0];
    int sel[2];
    int m;
    if (sc.prev_seen && t < sc.prev_t) begin
      queue_result(ST_BACK, -1, 1'b1);
      return;
    end
    nx = sc;
    nhit = 0;
    if (creg[REG_WEAPON][1:0] == WPN_EPEE) begin
      m = run_epee(s, sel);
    end else begin
      m = run_latched(s, creg[REG_WEAPON][1:0] == WPN_FOIL);
      sel[0] = 0;
      sel[1] = 1;
    end
    if (m < 0) begin
      queue_result(ST_OVF, -1, 1'b1);
      return;
    end
    nx.prev_seen = 1;
    nx.prev_t = t;
    sc = nx;
    if (m == 0) queue_result(ST_OK, -1, 1'b1);
    for (int i = 0; i < m; i++) queue_result(ST_OK, sel[i], i == m - 1);
  endfunction

  // monitor: track config writes, accepted samples and results
  always @(posedge clk) begin
    logic [104:0] want;
    if (!rst_n) begin
      sc = '{default: '0};
      for (int i = 0; i < 8; i++) creg[i] = cfg_reset_value(i);
      results_due.delete();
      quiet <= 1;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result: got %h last %b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = results_due.pop_front();
          if ({out_tlast, out_tdata} !== want) begin
            $display("%0t: result mismatch: expected %h last %b, got %h last %b",
                     $time, want[103:0], want[104], out_tdata, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_we) creg[cfg_index] = cfg_index == REG_WEAPON ? {18'd0, cfg_wdata[1:0]}
                                                           : cfg_wdata;
      if (in_tvalid && in_tready) score_sample(in_tdata[57:0]);
      quiet <= results_due.size() == 0;
    end
  end

  // driver: offer pending samples, idle at random, hold gated samples until drained
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = idle_mode == 0 ? 27 : idle_mode == 1 ? 86 : 0;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1;
    end else if (samples_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                 (!samples_todo[0].gate || (!in_tvalid && quiet))) begin
      in_tvalid <= 1;
      in_tdata <= {6'd0, samples_todo.pop_front().d};
    end else begin
      in_tvalid <= 0;
    end
  end

  // receiver: random back-pressure plus long hold-offs on request
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = idle_mode == 0 ? 86 : idle_mode == 1 ? 27 : 0;
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= idle_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL fencing_hit_qualifier");
      $finish;
    end
  end

  function automatic void add_sample(logic [47:0] t, logic [9:0] ln, bit gate = 0);
    sample_t s;
    s.d = {ln, t};
    s.gate = gate;
    samples_todo.push_back(s);
  endfunction

  // timestamps mostly advance; contact lines persist and toggle now and then
  function automatic void add_random(int n, int gate_at = -1);
    logic [47:0] t;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3 && cur_t > 1000) begin
        t = cur_t - $urandom_range(1, 1000);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) cur_t = cur_t;
        else if (r < 70) cur_t = cur_t + $urandom_range(1, 400);
        else if (r < 95) cur_t = cur_t + $urandom_range(400, 8000);
        else cur_t = cur_t + $urandom_range(8000, 400000);
        t = cur_t;
      end
      for (int b = 0; b < 10; b++)
        if ($urandom_range(0, 99) < 12) cur_lines[b] = ~cur_lines[b];
      add_sample(t, cur_lines, i == gate_at);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_todo.size() != 0 || in_tvalid || !quiet);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    // sabre code three, instant touches, lockout end past the time range
    write_cfg(REG_WEAPON, {18'd0, WPN_ALT});
    write_cfg(REG_SABRE_MIN, '0);
    write_cfg(REG_SABRE_LOCK, CFG_MAX);
    add_sample(48'd0, 10'b00100_00100);
    add_sample(48'd10, 10'b11111_11111);
    add_sample(TIME_MAX - 48'd5, 10'b00100_00000);
    add_sample(48'd5, 10'b00100_00100);
    add_sample(48'd20, 10'b10101_10101);
    cur_t = 48'd20;
    wait_drained();

    // sabre with the longest touch time: blade history and white lamps
    write_cfg(REG_WEAPON, {18'd0, WPN_SABRE});
    write_cfg(REG_SABRE_MIN, CFG_MAX);
    write_cfg(REG_SABRE_BREAK, '0);
    add_random(300);
    wait_drained();

    // epee: right touch starts first and comes out first
    idle_mode = 1;
    write_cfg(REG_WEAPON, {18'd0, WPN_EPEE});
    write_cfg(REG_EPEE_MIN, 20'd2000);
    write_cfg(REG_EPEE_WIN, 20'd45000);
    add_sample(cur_t, '0);
    add_sample(cur_t, 10'b00001_00000);
    add_sample(cur_t + 48'd5, 10'b00001_00001);
    add_sample(cur_t + 48'd2005, 10'b00001_00001);
    add_sample(cur_t + 48'd60000, 10'b00001_00001);
    cur_t = cur_t + 48'd60000;
    add_random(400, 200);
    wait_drained();

    // foil, with one long receiver hold-off while samples keep coming
    write_cfg(REG_WEAPON, {18'd0, WPN_FOIL});
    write_cfg(REG_FOIL_MIN, '0);
    write_cfg(REG_FOIL_LOCK, '0);
    hold_req++;
    add_random(400);
    wait_drained();

    idle_mode = 2;
    write_cfg(REG_WEAPON, {18'd0, WPN_SABRE});
    write_cfg(REG_SABRE_BREAK, CFG_MAX);
    write_cfg(REG_SABRE_LOCK, '0);
    write_cfg(REG_SABRE_MIN, 20'd1);
    add_random(400);
    wait_drained();

    // epee with the epee and foil registers at their upper extreme
    write_cfg(REG_WEAPON, {18'd0, WPN_EPEE});
    write_cfg(REG_EPEE_MIN, CFG_MAX);
    write_cfg(REG_EPEE_WIN, CFG_MAX);
    write_cfg(REG_FOIL_MIN, CFG_MAX);
    write_cfg(REG_FOIL_LOCK, CFG_MAX);
    add_random(400);
    wait_drained();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("PASS fencing_hit_qualifier");
    end else begin
      $display("FAIL fencing_hit_qualifier");
    end
    $finish;
  end
endmodule
`default_nettype wire
